/* rtl/lrl_pkg.sv */
// lrl_pkg: shared constants for the LRU recency list core.
// Holds port field widths and parameter defaults; depends on nothing.
`timescale 1ns / 1ps

package lrl_pkg;

   // Default list geometry
   localparam int SLOTS_DEFAULT    = 8;
   localparam int KEY_BITS_DEFAULT = 8;

   // Fixed widths of the port fields
   localparam int KEY_W      = 8;
   localparam int HIT_SLOT_W = 3;
   localparam int EVICT_W    = 8;
   localparam int LIST_W     = 64;

endpackage

/* rtl/lru_recency_list_core.sv */
// lru_recency_list_core: top level of the LRU recency list.
// A request waits in the input register, then moves to the result register and raises rsp_valid.
// Throughput: one request per cycle unless rsp_ready stalls; compare and shift are combinational.
// Reset (synchronous, active high) clears every slot to zero and drops pending requests.
// Depends on lrl_pkg, lrl_match and lrl_shift.
`timescale 1ns / 1ps

module lru_recency_list_core #(
   parameter int SLOTS    = lrl_pkg::SLOTS_DEFAULT,
   parameter int KEY_BITS = lrl_pkg::KEY_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lrl_pkg::KEY_W-1:0]        req_key,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [lrl_pkg::HIT_SLOT_W-1:0]   rsp_hit_slot,
   output logic [lrl_pkg::EVICT_W-1:0]      rsp_evicted_key,
   output logic [lrl_pkg::LIST_W-1:0]       rsp_list_after
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int FLAT_W = SLOTS * KEY_BITS;

   // input stage
   logic                s1_valid_ff;
   logic [KEY_BITS-1:0] s1_key_ff;
   logic [KEY_BITS-1:0] key_trim;

   // list state
   logic [KEY_BITS-1:0] slot_ff [SLOTS];
   logic [KEY_BITS-1:0] slot_in [SLOTS];

   // match and update
   logic                hit;
   logic [IDX_W-1:0]    hit_at;
   logic [IDX_W-1:0]    shift_from;
   logic [KEY_BITS-1:0] evicted;
   logic [FLAT_W-1:0]   list_flat;

   // result register
   logic                              rsp_valid_ff;
   logic                              rsp_hit_ff;
   logic [lrl_pkg::HIT_SLOT_W-1:0]    rsp_hit_slot_ff;
   logic [lrl_pkg::HIT_SLOT_W-1:0]    rsp_hit_slot_in;
   logic [lrl_pkg::EVICT_W-1:0]       rsp_evicted_ff;
   logic [lrl_pkg::EVICT_W-1:0]       rsp_evicted_in;
   logic [lrl_pkg::LIST_W-1:0]        rsp_list_ff;
   logic [lrl_pkg::LIST_W-1:0]        rsp_list_in;

   logic advance;

   // Advance the held request into the result register when that register is free
   // or being drained this cycle.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // Keep the low KEY_BITS bits of the incoming key, zero-extending it when KEY_BITS is wider than KEY_W.
   generate
      if (KEY_BITS <= lrl_pkg::KEY_W) begin : g_key_narrow
         assign key_trim = req_key[KEY_BITS-1:0];
      end else begin : g_key_wide
         assign key_trim = {{(KEY_BITS - lrl_pkg::KEY_W){1'b0}}, req_key};
      end
   endgenerate

   // Hold the request in the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_key_ff <= key_trim;
      end
   end

   lrl_match #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_match (
      .key       (s1_key_ff),
      .slot_keys (slot_ff),
      .hit       (hit),
      .hit_at    (hit_at)
   );

   // A miss drops slot 0, so the whole list moves down from there.
   assign shift_from = hit ? hit_at : '0;

   lrl_shift #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_shift (
      .key        (s1_key_ff),
      .shift_from (shift_from),
      .slot_keys  (slot_ff),
      .slot_next  (slot_in)
   );

   assign evicted = hit ? '0 : slot_ff[0];

   // Pack the updated list, slot i at bits KEY_BITS*i and up.
   generate
      for (genvar i = 0; i < SLOTS; i++) begin : g_flat
         assign list_flat[i*KEY_BITS +: KEY_BITS] = slot_in[i];
      end

      if (FLAT_W >= lrl_pkg::LIST_W) begin : g_list_trunc
         assign rsp_list_in = list_flat[lrl_pkg::LIST_W-1:0];
      end else begin : g_list_ext
         assign rsp_list_in = {{(lrl_pkg::LIST_W - FLAT_W){1'b0}}, list_flat};
      end

      if (IDX_W >= lrl_pkg::HIT_SLOT_W) begin : g_slot_trunc
         assign rsp_hit_slot_in = shift_from[lrl_pkg::HIT_SLOT_W-1:0];
      end else begin : g_slot_ext
         assign rsp_hit_slot_in = {{(lrl_pkg::HIT_SLOT_W - IDX_W){1'b0}}, shift_from};
      end

      if (KEY_BITS >= lrl_pkg::EVICT_W) begin : g_evict_trunc
         assign rsp_evicted_in = evicted[lrl_pkg::EVICT_W-1:0];
      end else begin : g_evict_ext
         assign rsp_evicted_in = {{(lrl_pkg::EVICT_W - KEY_BITS){1'b0}}, evicted};
      end
   endgenerate

   // Update the list once per advanced request; reset clears it to zeros.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_ff[i] <= '0;
         end
      end else if (advance) begin
         slot_ff <= slot_in;
      end
   end

   // Result register: load on advance, drop valid once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff      <= hit;
         rsp_hit_slot_ff <= rsp_hit_slot_in;
         rsp_evicted_ff  <= rsp_evicted_in;
         rsp_list_ff     <= rsp_list_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_hit_slot    = rsp_hit_slot_ff;
   assign rsp_evicted_key = rsp_evicted_ff;
   assign rsp_list_after  = rsp_list_ff;

   // A miss always reports slot 0.
   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_hit_slot_ff == '0)
      else $error("miss reported a nonzero hit slot");

   // A hit evicts nothing.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_evicted_ff == '0)
      else $error("hit reported an evicted key");

   // The advanced key lands in the most recent slot.
   a_top_slot: assert property (@(posedge clock) disable iff (reset)
      advance |=> slot_ff[SLOTS-1] == $past(s1_key_ff))
      else $error("top slot does not hold the last key");

   // A stalled request stays in the input register.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_key_ff))
      else $error("held request lost while stalled");

endmodule

/* rtl/lrl_match.sv */
// lrl_match: compares one key against every list slot and finds the lowest match.
// Depends on lrl_pkg for parameter defaults.
`timescale 1ns / 1ps

module lrl_match #(
   parameter int SLOTS    = lrl_pkg::SLOTS_DEFAULT,
   parameter int KEY_BITS = lrl_pkg::KEY_BITS_DEFAULT,
   localparam int IDX_W   = $clog2(SLOTS)
) (
   input  logic [KEY_BITS-1:0] key,
   input  logic [KEY_BITS-1:0] slot_keys [SLOTS],
   output logic                hit,
   output logic [IDX_W-1:0]    hit_at
);

   logic [SLOTS-1:0] match;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = (slot_keys[i] == key);
      end
   end

   // lowest matching slot wins; zero on a miss
   always_comb begin
      hit_at = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_at = IDX_W'(i);
         end
      end
   end

   assign hit = |match;

endmodule

/* rtl/lrl_shift.sv */
// lrl_shift: next-state network for the recency list (close the gap, insert on top).
// Depends on lrl_pkg for parameter defaults.
`timescale 1ns / 1ps

module lrl_shift #(
   parameter int SLOTS    = lrl_pkg::SLOTS_DEFAULT,
   parameter int KEY_BITS = lrl_pkg::KEY_BITS_DEFAULT,
   localparam int IDX_W   = $clog2(SLOTS)
) (
   input  logic [KEY_BITS-1:0] key,
   input  logic [IDX_W-1:0]    shift_from,
   input  logic [KEY_BITS-1:0] slot_keys [SLOTS],
   output logic [KEY_BITS-1:0] slot_next [SLOTS]
);

   // slots at or above the removal point take their upper neighbor
   always_comb begin
      for (int i = 0; i < SLOTS - 1; i++) begin
         if (IDX_W'(i) >= shift_from) begin
            slot_next[i] = slot_keys[i+1];
         end else begin
            slot_next[i] = slot_keys[i];
         end
      end
      slot_next[SLOTS-1] = key;
   end

endmodule

/* sim/tb_top.sv */
// tb_top: self-checking testbench for lru_recency_list_core (eight-slot LRU key list).
// Depends on rtl/lrl_pkg.sv and the core RTL; a built-in recency predictor checks responses.
`timescale 1ns / 1ps

module tb_top;

   localparam int KEY_W         = lrl_pkg::KEY_W;
   localparam int HIT_SLOT_W    = lrl_pkg::HIT_SLOT_W;
   localparam int EVICT_W       = lrl_pkg::EVICT_W;
   localparam int LIST_W        = lrl_pkg::LIST_W;
   localparam int LIST_SLOTS    = lrl_pkg::SLOTS_DEFAULT;
   localparam int DIRECTED_KEYS = 20;
   localparam int RANDOM_KEYS   = 1430;
   localparam int QUIET_TAIL    = 150;
   localparam int STALL_LIMIT   = 1000;
   localparam int DRAIN_CYCLES  = 8;

   typedef struct packed {
      logic [KEY_W-1:0]      key;
      logic                  hit;
      logic [HIT_SLOT_W-1:0] hit_slot;
      logic [EVICT_W-1:0]    evicted_key;
      logic [LIST_W-1:0]     list_after;
   } lru_lookup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [KEY_W-1:0] req_key   = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic                  rsp_hit;
   logic [HIT_SLOT_W-1:0] rsp_hit_slot;
   logic [EVICT_W-1:0]    rsp_evicted_key;
   logic [LIST_W-1:0]     rsp_list_after;

   // Stimulus and scoreboard state
   logic [KEY_W-1:0] pending_keys[$];
   lru_lookup_type   expected_lookups[$];
   logic [KEY_W-1:0] recency_slots[LIST_SLOTS];

   int  total_keys      = 0;
   int  keys_accepted   = 0;
   int  lookups_checked = 0;
   int  hits_seen       = 0;
   int  mismatches      = 0;
   int  quiet_cycles    = 0;
   logic req_taken      = 1'b0;
   int  req_gap_left    = 0;
   int  rsp_stall_left  = 0;

   always #5 clock = ~clock;

   lru_recency_list_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_hit_slot    (rsp_hit_slot),
      .rsp_evicted_key (rsp_evicted_key),
      .rsp_list_after  (rsp_list_after)
   );

   // Look the key up in the recency list, update the list, return the expected response.
   function automatic lru_lookup_type touch_key(input logic [KEY_W-1:0] key);
      lru_lookup_type r;
      int             found;
      int             first;
      found = -1;
      r = '0;
      r.key = key;
      for (int i = 0; i < LIST_SLOTS; i++) begin
         if (found < 0 && recency_slots[i] == key)
            found = i;
      end
      r.hit = (found >= 0);
      if (r.hit) begin
         r.hit_slot = found[HIT_SLOT_W-1:0];
         first = found;
      end else begin
         r.evicted_key = recency_slots[0];
         first = 0;
      end
      for (int i = first; i < LIST_SLOTS - 1; i++)
         recency_slots[i] = recency_slots[i + 1];
      recency_slots[LIST_SLOTS - 1] = key;
      for (int i = 0; i < LIST_SLOTS; i++)
         r.list_after[i*KEY_W +: KEY_W] = recency_slots[i];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [LIST_W-1:0] want,
                              input logic [LIST_W-1:0] got, input logic [KEY_W-1:0] key);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH key=%0h %s: expected %0h, got %0h", key, name, want, got);
      end
   endtask

   // Drive the request channel at the falling edge.
   always @(negedge clock) begin
      logic             next_valid;
      logic [KEY_W-1:0] next_key;
      logic             idling_on;
      next_valid = req_valid;
      next_key   = req_key;
      idling_on  = (pending_keys.size() > QUIET_TAIL) && ((keys_accepted / 160) % 3 != 2);
      if (!reset && !(req_valid && !req_taken)) begin
         if (req_valid && req_taken && idling_on && $urandom_range(3) == 0)
            req_gap_left = $urandom_range(8, 1);
         if (req_gap_left > 0) begin
            next_valid = 1'b0;
            req_gap_left--;
         end else if (pending_keys.size() > 0) begin
            next_valid = 1'b1;
            next_key   = pending_keys.pop_front();
         end else begin
            next_valid = 1'b0;
         end
      end
      req_valid <= next_valid;
      req_key   <= next_key;
   end

   // Drive response back-pressure at the falling edge.
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (pending_keys.size() > QUIET_TAIL && ((keys_accepted / 200) % 3 != 1)
             && $urandom_range(4) == 0)
            rsp_stall_left = $urandom_range(8, 1);
      end
   end

   // Sample both channels at the rising edge: predict on accept, check on response.
   always @(posedge clock) begin
      lru_lookup_type want;
      logic           moved;
      moved = 1'b0;
      req_taken <= 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_lookups.push_back(touch_key(req_key));
            keys_accepted <= keys_accepted + 1;
            req_taken <= 1'b1;
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (expected_lookups.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("MISMATCH unexpected response: hit=%0b slot=%0d list=%h",
                           rsp_hit, rsp_hit_slot, rsp_list_after);
            end else begin
               want = expected_lookups.pop_front();
               check_field("hit", LIST_W'(want.hit), LIST_W'(rsp_hit), want.key);
               check_field("hit_slot", LIST_W'(want.hit_slot), LIST_W'(rsp_hit_slot),
                           want.key);
               check_field("evicted_key", LIST_W'(want.evicted_key),
                           LIST_W'(rsp_evicted_key), want.key);
               check_field("list_after", want.list_after, rsp_list_after, want.key);
               lookups_checked <= lookups_checked + 1;
               if (want.hit)
                  hits_seen <= hits_seen + 1;
            end
         end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0] directed[DIRECTED_KEYS];
      logic [KEY_W-1:0] window_base;
      // Cleared list: key 0 hits at slot 0 among duplicate zeros; then fill with misses,
      // hit at the top, the bottom and the middle, and cover every key bit both ways.
      directed = '{8'h00, 8'h00, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                   8'h08, 8'h08, 8'h01, 8'h05, 8'h09, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'h00};
      foreach (directed[i])
         pending_keys.push_back(directed[i]);
      // Mostly keys drawn from a small moving window, so hits land on every slot;
      // the rest is full-range noise that forces misses and evictions.
      window_base = '0;
      for (int n = 0; n < RANDOM_KEYS; n++) begin
         if (n % 64 == 0)
            window_base = KEY_W'($urandom_range(255));
         if ($urandom_range(9) < 7)
            pending_keys.push_back(window_base + KEY_W'($urandom_range(10)));
         else
            pending_keys.push_back(KEY_W'($urandom_range(255)));
      end
      total_keys = pending_keys.size();
      foreach (recency_slots[i])
         recency_slots[i] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (keys_accepted < total_keys || expected_lookups.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_lookups.size() != 0) begin
         mismatches++;
         $display("%0d responses never arrived", expected_lookups.size());
      end
      $display("checked %0d lookups (%0d hits, %0d misses) over %0d requests",
               lookups_checked, hits_seen, lookups_checked - hits_seen, keys_accepted);
      $display("mismatched fields or responses: %0d", mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* lru_recency_list_core.f */
rtl/lrl_pkg.sv
rtl/lrl_match.sv
rtl/lrl_shift.sv
rtl/lru_recency_list_core.sv
sim/tb_top.sv
